### sv/disk_request_scheduler_macros.svh
// Assertion macros shared by the disk request scheduler checkers.
// Needs clk and rst in the scope where a macro is used.
`ifndef DISK_REQUEST_SCHEDULER_MACROS_SVH
`define DISK_REQUEST_SCHEDULER_MACROS_SVH

// Same-cycle implication, skipped during reset.
`define DSCH_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("scheduler check failed");

// Next-cycle implication, skipped during reset.
`define DSCH_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("scheduler check failed");

`endif

### sv/dsch_pkg.sv
// Shared types and constants of the disk request scheduler.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package dsch_pkg;

  localparam int MAX_REQUESTS_DEF = 32;
  localparam int CYL_BITS_DEF     = 10;
  localparam int SUM_W            = 16;
  localparam int POLICY_W         = 3;
  localparam int CFG_ADDR_W       = 2;
  localparam int START_RESET      = 101;
  localparam int MAX_RESET        = 199;
  localparam int MIN_RESET        = 0;

  localparam logic [CFG_ADDR_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX    = 2'd3;

  localparam logic [POLICY_W-1:0] POL_FCFS  = 3'd0;
  localparam logic [POLICY_W-1:0] POL_SSTF  = 3'd1;
  localparam logic [POLICY_W-1:0] POL_SCAN  = 3'd2;
  localparam logic [POLICY_W-1:0] POL_CSCAN = 3'd3;
  localparam logic [POLICY_W-1:0] POL_LOOK  = 3'd4;
  localparam logic [POLICY_W-1:0] POL_CLOOK = 3'd5;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_RUN = 1'b1;

  typedef enum logic [1:0] {MODE_PRE, MODE_FCFS, MODE_SSTF, MODE_SWEEP} mode_t;
  typedef enum logic [1:0] {CLS_BELOW, CLS_ABOVE, CLS_EQUAL, CLS_ANY} cls_t;
  typedef enum logic [1:0] {SEL_BEST, SEL_START, SEL_MIN, SEL_MAX} sel_t;

  typedef struct packed {
    logic  add;
    logic  run_init;
    logic  scan_start;
    logic  emit;
    logic  clear;
    logic  end_stop;
    mode_t mode;
    cls_t  cls;
    logic  desc;
    sel_t  sel;
  } cmd_t;

  typedef struct packed {
    logic                scan_done;
    logic                found;
    logic                below;
    logic                above;
    logic                count_zero;
    logic                out_free;
    logic                last;
    logic                down;
    logic [POLICY_W-1:0] policy;
  } status_t;

endpackage
`default_nettype wire

### sv/dsch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dsch_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/dsch_ctrl.sv
// Scheduler controller: walks the run through prescan, search and emit steps.
// Depends on dsch_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none
module dsch_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  input  wire logic               req_type,
  input  wire dsch_pkg::status_t  st,
  output logic                    s_tready,
  output dsch_pkg::cmd_t          cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EMPTY = 6'b000010,
    S_PRE   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_ENDS  = 6'b100000
  } state_t;

  typedef enum logic [5:0] {
    PH_ALL = 6'b000001,
    PH_EQ  = 6'b000010,
    PH_A   = 6'b000100,
    PH_E1  = 6'b001000,
    PH_E2  = 6'b010000,
    PH_B   = 6'b100000
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  logic is_sstf, is_sweep, is_cscan, wrap, ends_on, b_desc;

  always_comb begin
    is_sstf  = st.policy == dsch_pkg::POL_SSTF;
    is_cscan = st.policy == dsch_pkg::POL_CSCAN;
    is_sweep = st.policy == dsch_pkg::POL_SCAN || st.policy == dsch_pkg::POL_CSCAN ||
               st.policy == dsch_pkg::POL_LOOK || st.policy == dsch_pkg::POL_CLOOK;
    wrap     = st.policy == dsch_pkg::POL_CSCAN || st.policy == dsch_pkg::POL_CLOOK;
    ends_on  = (st.policy == dsch_pkg::POL_SCAN || is_cscan) && st.below && st.above;
    b_desc   = st.down ? wrap : !wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_ALL;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.sel    = dsch_pkg::SEL_BEST;

    // search setup follows the current phase
    unique case (phase)
      PH_EQ: begin
        cmd.cls  = dsch_pkg::CLS_EQUAL;
        cmd.mode = dsch_pkg::MODE_SWEEP;
      end
      PH_A: begin
        cmd.cls  = st.down ? dsch_pkg::CLS_BELOW : dsch_pkg::CLS_ABOVE;
        cmd.desc = st.down;
        cmd.mode = dsch_pkg::MODE_SWEEP;
      end
      PH_B: begin
        cmd.cls  = st.down ? dsch_pkg::CLS_ABOVE : dsch_pkg::CLS_BELOW;
        cmd.desc = b_desc;
        cmd.mode = dsch_pkg::MODE_SWEEP;
      end
      default: begin
        cmd.cls  = dsch_pkg::CLS_ANY;
        cmd.mode = is_sstf ? dsch_pkg::MODE_SSTF : dsch_pkg::MODE_FCFS;
      end
    endcase
    if (state == S_PRE) begin
      cmd.mode = dsch_pkg::MODE_PRE;
    end

    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (req_type == dsch_pkg::REQ_ADD) begin
            cmd.add = 1'b1;
          end else begin
            cmd.run_init = 1'b1;
            if (st.count_zero) begin
              state_next = S_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_PRE;
            end
          end
        end
      end
      S_EMPTY: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = dsch_pkg::SEL_START;
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PRE: begin
        if (st.scan_done) begin
          phase_next     = is_sweep ? PH_EQ : PH_ALL;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          if (st.found) begin
            state_next = S_EMIT;
          end else begin
            priority case (phase)
              PH_EQ: begin
                phase_next     = PH_A;
                cmd.scan_start = 1'b1;
              end
              PH_A: begin
                if (ends_on) begin
                  phase_next = PH_E1;
                  state_next = S_ENDS;
                end else begin
                  phase_next     = PH_B;
                  cmd.scan_start = 1'b1;
                end
              end
              default: begin
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
              end
            endcase
          end
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_ENDS: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.end_stop = 1'b1;
          if (phase == PH_E1) begin
            cmd.sel = st.down ? dsch_pkg::SEL_MIN : dsch_pkg::SEL_MAX;
          end else begin
            cmd.sel = st.down ? dsch_pkg::SEL_MAX : dsch_pkg::SEL_MIN;
          end
          if (phase == PH_E1 && is_cscan) begin
            phase_next = PH_E2;
          end else begin
            phase_next     = PH_B;
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/dsch_dp.sv
// Scheduler datapath: config registers, request RAM, served marks, search and
// result register. Depends on dsch_pkg and dsch_ram.
`default_nettype none
module dsch_dp #(
  parameter int MAX_REQUESTS = dsch_pkg::MAX_REQUESTS_DEF,
  parameter int CYL_BITS     = dsch_pkg::CYL_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dsch_pkg::cmd_t                    cmd,
  output dsch_pkg::status_t                      st,
  input  wire logic                              cfg_we,
  input  wire logic [dsch_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [CYL_BITS-1:0]               cfg_data,
  input  wire logic [CYL_BITS-1:0]               cylinder,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [CYL_BITS-1:0]                    out_stop,
  output logic [CYL_BITS-1:0]                    out_step,
  output logic [dsch_pkg::SUM_W-1:0]             out_total,
  output logic                                   out_end,
  output logic                                   out_last,
  output logic                                   out_drop,
  output logic                                   out_empty
);

  localparam int IDX_W = MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int SUM_W = dsch_pkg::SUM_W;

  logic [dsch_pkg::POLICY_W-1:0] policy;
  logic [CYL_BITS-1:0] start_cyl, min_cyl, max_cyl;

  logic [CNT_W-1:0] count, served, cnt_m1;
  logic [IDX_W-1:0] last_idx, sidx, ridx, best_i;
  logic [MAX_REQUESTS-1:0] marks;
  logic drop, below, above, running, rv, have_best;
  logic [CYL_BITS-1:0] head, best_v, best_d, rdata, cand_d, emit_v, emit_d;
  logic [SUM_W-1:0] sum, sum_sat;
  logic [SUM_W:0] sum_wide;
  logic add_ok, cls_ok, better, take;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= dsch_pkg::POL_FCFS;
      start_cyl <= CYL_BITS'(dsch_pkg::START_RESET);
      min_cyl   <= CYL_BITS'(dsch_pkg::MIN_RESET);
      max_cyl   <= CYL_BITS'(dsch_pkg::MAX_RESET);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dsch_pkg::REG_POLICY: policy    <= cfg_data[dsch_pkg::POLICY_W-1:0];
        dsch_pkg::REG_START:  start_cyl <= cfg_data;
        dsch_pkg::REG_MIN:    min_cyl   <= cfg_data;
        dsch_pkg::REG_MAX:    max_cyl   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign add_ok   = cmd.add && cylinder >= min_cyl && cylinder <= max_cyl &&
                    count < CNT_W'(MAX_REQUESTS);
  assign cnt_m1   = count - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];

  dsch_ram #(.WIDTH(CYL_BITS), .DEPTH(MAX_REQUESTS)) u_store (
    .clk   (clk),
    .we    (add_ok),
    .waddr (count[IDX_W-1:0]),
    .wdata (cylinder),
    .raddr (sidx),
    .rdata (rdata)
  );

  // address walk; the registered read data lines up with ridx, both taken from sidx
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      rv      <= 1'b0;
    end else begin
      rv <= running && !cmd.scan_start;
      if (cmd.scan_start) begin
        running <= 1'b1;
      end else if (running && sidx == last_idx) begin
        running <= 1'b0;
      end
    end
    if (cmd.scan_start) begin
      sidx <= '0;
    end else if (running) begin
      sidx <= sidx + IDX_W'(1);
    end
    ridx <= sidx;
  end

  always_comb begin
    cand_d = rdata > head ? rdata - head : head - rdata;
    unique case (cmd.cls)
      dsch_pkg::CLS_BELOW: cls_ok = rdata < start_cyl;
      dsch_pkg::CLS_ABOVE: cls_ok = rdata > start_cyl;
      dsch_pkg::CLS_EQUAL: cls_ok = rdata == start_cyl;
      default:             cls_ok = 1'b1;
    endcase
    unique case (cmd.mode)
      dsch_pkg::MODE_SSTF:  better = !have_best || cand_d < best_d;
      dsch_pkg::MODE_SWEEP: better = !have_best ||
                                     (cmd.desc ? rdata > best_v : rdata < best_v);
      dsch_pkg::MODE_FCFS:  better = !have_best;
      default:              better = 1'b0;
    endcase
    take = rv && cmd.mode != dsch_pkg::MODE_PRE && !marks[ridx] && cls_ok && better;
  end

  always_comb begin
    unique case (cmd.sel)
      dsch_pkg::SEL_START: emit_v = start_cyl;
      dsch_pkg::SEL_MIN:   emit_v = min_cyl;
      dsch_pkg::SEL_MAX:   emit_v = max_cyl;
      default:             emit_v = best_v;
    endcase
    emit_d   = emit_v > head ? emit_v - head : head - emit_v;
    sum_wide = {1'b0, sum} + (SUM_W + 1)'(emit_d);
    sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      served    <= '0;
      marks     <= '0;
      drop      <= 1'b0;
      below     <= 1'b0;
      above     <= 1'b0;
      have_best <= 1'b0;
      head      <= CYL_BITS'(dsch_pkg::START_RESET);
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.add) begin
        if (add_ok) begin
          count <= count + CNT_W'(1);
        end else begin
          drop <= 1'b1;
        end
      end
      if (cmd.run_init) begin
        head   <= start_cyl;
        sum    <= '0;
        served <= '0;
        below  <= 1'b0;
        above  <= 1'b0;
      end
      if (rv && cmd.mode == dsch_pkg::MODE_PRE) begin
        if (rdata < start_cyl) below <= 1'b1;
        if (rdata > start_cyl) above <= 1'b1;
      end
      if (cmd.scan_start) begin
        have_best <= 1'b0;
      end else if (take) begin
        have_best <= 1'b1;
      end
      if (cmd.emit) begin
        head      <= emit_v;
        sum       <= sum_sat;
        out_valid <= 1'b1;
        if (cmd.sel == dsch_pkg::SEL_BEST) begin
          served <= served + CNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // drop the store at the end of a run, else mark the stop just served
      if (cmd.clear) begin
        count <= '0;
        marks <= '0;
        drop  <= 1'b0;
      end else if (cmd.emit && cmd.sel == dsch_pkg::SEL_BEST) begin
        marks[best_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_v <= rdata;
      best_i <= ridx;
      best_d <= cand_d;
    end
    if (cmd.emit) begin
      out_stop  <= emit_v;
      out_step  <= emit_d;
      out_total <= sum_sat;
      out_end   <= cmd.end_stop;
      out_drop  <= drop;
      out_empty <= cmd.sel == dsch_pkg::SEL_START;
      out_last  <= cmd.sel == dsch_pkg::SEL_START ||
                   (cmd.sel == dsch_pkg::SEL_BEST && st.last);
    end
  end

  always_comb begin
    st.scan_done  = rv && ridx == last_idx;
    st.found      = have_best || take;
    st.below      = below;
    st.above      = above;
    st.count_zero = count == '0;
    st.out_free   = !out_valid || out_ready;
    st.last       = (served + CNT_W'(1)) == count;
    st.down       = start_cyl <= (max_cyl >> 1);
    st.policy     = policy;
  end

endmodule
`default_nettype wire

### sv/disk_request_scheduler.sv
// Top level of the disk request scheduler: stream ports, controller, datapath.
// Depends on dsch_pkg, dsch_ctrl and dsch_dp.
//
// channel   direction  beat contents
// s_*       in         add request or run command
// m_*       out        one service stop per beat, tlast on the final stop
// cfg_*     in         register write, no response
//
// An add beat is stored as it is accepted. A run beat over N stored requests takes a
// prescan pass, then a RAM walk plus one emit per request stop, since each stop
// is chosen by a full pass through the single read port; a sweep adds one dry
// pass for each phase that runs out (at most two), end stops are emitted without
// a pass, and an empty run emits its one stop from the empty state after accept.
// Reset is synchronous and leaves the store empty at once.
// s_tready is low for the whole run; a stalled m_* beat holds the controller.
`default_nettype none
module disk_request_scheduler #(
  parameter int MAX_REQUESTS = dsch_pkg::MAX_REQUESTS_DEF,
  parameter int CYL_BITS     = dsch_pkg::CYL_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // cylinder
  input  wire logic [((CYL_BITS+7)/8)*8-1:0]   s_tdata,
  // req_type
  input  wire logic [0:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // stop_cylinder, step_distance, total_distance
  output logic [((2*CYL_BITS+dsch_pkg::SUM_W+7)/8)*8-1:0] m_tdata,
  // is_end_stop, dropped_requests, queue_empty
  output logic [2:0]                           m_tuser,
  output logic                                 m_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [dsch_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CYL_BITS-1:0]             cfg_data
);

  localparam int OUT_W = ((2*CYL_BITS+dsch_pkg::SUM_W+7)/8)*8;

  dsch_pkg::cmd_t    cmd;
  dsch_pkg::status_t st;

  logic [CYL_BITS-1:0]       out_stop, out_step;
  logic [dsch_pkg::SUM_W-1:0] out_total;
  logic out_end, out_last, out_drop, out_empty;

  dsch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_type (s_tuser[0]),
    .st       (st),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  dsch_dp #(.MAX_REQUESTS(MAX_REQUESTS), .CYL_BITS(CYL_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cylinder  (s_tdata[CYL_BITS-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_stop  (out_stop),
    .out_step  (out_step),
    .out_total (out_total),
    .out_end   (out_end),
    .out_last  (out_last),
    .out_drop  (out_drop),
    .out_empty (out_empty)
  );

  assign m_tdata = OUT_W'({out_total, out_step, out_stop});
  assign m_tuser = {out_empty, out_drop, out_end};
  assign m_tlast = out_last;

endmodule
`default_nettype wire

### sv/dsch_checker.sv
// Port-level checks of the disk request scheduler, bound to the top level.
// Depends on dsch_pkg and disk_request_scheduler_macros.svh.
`default_nettype none
`include "disk_request_scheduler_macros.svh"
module dsch_checker #(
  parameter int CYL_BITS = dsch_pkg::CYL_BITS_DEF
) (
  input wire logic                                          clk,
  input wire logic                                          rst,
  input wire logic                                          s_tvalid,
  input wire logic                                          s_tready,
  input wire logic                                          m_tvalid,
  input wire logic                                          m_tready,
  input wire logic [((2*CYL_BITS+dsch_pkg::SUM_W+7)/8)*8-1:0] m_tdata,
  input wire logic [2:0]                                    m_tuser,
  input wire logic                                          m_tlast
);

  // a stalled beat holds its payload
  `DSCH_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // an empty run is a single, final beat
  `DSCH_ASSERT_IMP(a_empty_last, m_tvalid && m_tuser[2], m_tlast && !m_tuser[0])
  // an inserted boundary is never the final stop
  `DSCH_ASSERT_IMP(a_end_not_last, m_tvalid && m_tuser[0], !m_tlast)
  // input is taken only between runs, so no beat follows a run beat at once
  `DSCH_ASSERT_NXT(a_run_blocks, s_tvalid && s_tready && m_tvalid && !m_tready,
                   !s_tready || !m_tvalid || m_tready || $stable(m_tdata))

endmodule

bind disk_request_scheduler dsch_checker #(.CYL_BITS(CYL_BITS)) u_dsch_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire
